FILE: sv/wlaf_pkg.sv
// Shared types and constants for the water level alert filter.
// Used by every module of the block; depends on nothing.
package wlaf_pkg;

   // field widths
   localparam int ECHO_W      = 16;
   localparam int CFG_W       = 13;
   localparam int LEVEL_W     = 13;
   localparam int RISE_OUT_W  = 17;
   localparam int LEVEL_MAX   = 8191;

   // stream packing
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;

   // configuration port
   localparam int CSR_ADDR_W  = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRAIN_DEPTH = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SURGE_RISE  = 1'b1;
   localparam logic [CFG_W-1:0] DEPTH_RESET = 13'd4000;
   localparam logic [CFG_W-1:0] SURGE_RESET = 13'd50;

   // moving window length
   localparam int WINDOW_DEFAULT = 5;

   // distance = echo * 343 / 2000: divide by 16 with a shift, then by 125
   // through an exact reciprocal (x < 2^21, error term 44 < 2^28 / x)
   localparam int SOUND_MUL   = 343;
   localparam int PROD_W      = 25;
   localparam int PRE_SHIFT   = 4;
   localparam int DIV125_SHIFT = 28;
   localparam int DIV125_W    = 22;
   localparam logic [DIV125_W-1:0] DIV125_MUL = 22'd2147484;
   localparam int QUOT_W      = PROD_W - PRE_SHIFT + DIV125_W;
   localparam int DIST_W      = 14;

   // overflow threshold: 10 * sum >= 7 * WINDOW * depth
   localparam int OVF_NUM     = 10;
   localparam int OVF_DEN     = 7;

   // heartbeat
   localparam int HB_W        = 3;
   localparam logic [HB_W-1:0] HB_SAMPLES = 3'd6;

   typedef enum logic [1:0] {
      ALERT_NORMAL   = 2'd0,
      ALERT_SURGE    = 2'd1,
      ALERT_OVERFLOW = 2'd2
   } alert_type;

   // level token between the distance pipe and the window
   typedef struct packed {
      logic               clr;
      logic [LEVEL_W-1:0] level;
   } level_tok_type;

   // one result, filtered level in the lowest bits
   typedef struct packed {
      logic                  heartbeat;
      logic                  notify;
      alert_type             alert;
      logic [RISE_OUT_W-1:0] rise;
      logic [LEVEL_W-1:0]    filtered;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

FILE: sv/water_level_alert_filter_top.sv
// Top level of the water level alert filter: stream ports, configuration registers,
// and the level pipe, moving window and alert pipe. Uses wlaf_pkg and all wlaf_* modules.
//
//   channel   dir   handshake             payload
//   req_      in    req_tvalid/tready     tdata: echo_us; tuser: action
//   rsp_      out   rsp_tvalid/tready     tdata: level, rise, alert, notify, heartbeat
//   csr_      in    csr_we                csr_addr, csr_wdata
//
// One item per cycle sustained while results are accepted; a sample's result passes through
// the six register stages (three for distance and level, one window, two alert).
// Timeout samples are dropped at entry and clear items end in the window; neither gives a result.
// Reset is synchronous; the block is ready in the cycle after reset drops.
// A stalled result holds its stage; earlier empty stages keep filling, so input stalls
// only once every stage is occupied.
module water_level_alert_filter_top
   import wlaf_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // slave side
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] echo_us
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [0] action (1 = clear)
   // master side
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [12:0] filtered_level_mm,
                                               // [29:13] rise_fifths_mm, [31:30] alert,
                                               // [32] notify, [33] heartbeat, rest zero
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int SUM_W = $clog2(LEVEL_MAX * WINDOW + 1);

   logic [CFG_W-1:0] depth_ff, depth_in, surge_ff, surge_in;
   logic             lvl_valid, lvl_ready, win_valid, win_ready;
   level_tok_type    lvl_tok;
   logic [SUM_W-1:0] win_sum, win_prev;
   result_type       result;

   // configuration writes
   always_comb begin
      depth_in = depth_ff;
      surge_in = surge_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_DRAIN_DEPTH: depth_in = csr_wdata;
            CSR_SURGE_RISE:  surge_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
         surge_ff <= SURGE_RESET;
      end else begin
         depth_ff <= depth_in;
         surge_ff <= surge_in;
      end
   end

   wlaf_level u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_clear  (req_tuser[0]),
      .in_echo   (req_tdata[ECHO_W-1:0]),
      .depth     (depth_ff),
      .out_valid (lvl_valid),
      .out_ready (lvl_ready),
      .out_tok   (lvl_tok)
   );

   wlaf_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_ready  (lvl_ready),
      .in_tok    (lvl_tok),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_sum   (win_sum),
      .out_prev  (win_prev)
   );

   wlaf_alert #(
      .WINDOW (WINDOW)
   ) u_alert (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .in_ready   (win_ready),
      .in_sum     (win_sum),
      .in_prev    (win_prev),
      .depth      (depth_ff),
      .surge      (surge_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RESULT_W){1'b0}}, result};

endmodule

FILE: sv/wlaf_cell.sv
// One cell of the moving window: holds a single level sample.
// Loads the fill value on a first sample, else takes its neighbor's value on a shift.
module wlaf_cell
   import wlaf_pkg::*;
(
   input  logic               clock,
   input  logic               fill,
   input  logic               shift,
   input  logic [LEVEL_W-1:0] fill_level,
   input  logic [LEVEL_W-1:0] d_in,
   output logic [LEVEL_W-1:0] q_out
);

   logic [LEVEL_W-1:0] q_ff;
   logic [LEVEL_W-1:0] q_in;

   // fill wins over shift; hold otherwise
   always_comb begin
      q_in = q_ff;
      if (fill) begin
         q_in = fill_level;
      end else if (shift) begin
         q_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q_out = q_ff;

endmodule

FILE: sv/wlaf_level.sv
// Echo-to-level pipe: three stages turning echo time into a clamped water level.
// Drops timeout samples at entry; clear tokens pass through. Uses wlaf_pkg.
module wlaf_level
   import wlaf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_clear,
   input  logic [ECHO_W-1:0] in_echo,
   input  logic [CFG_W-1:0]  depth,
   output logic              out_valid,
   input  logic              out_ready,
   output level_tok_type     out_tok
);

   logic              v1_ff, v1_in, clr1_ff;
   logic [PROD_W-1:0] prod1_ff, prod1_in;
   logic              v2_ff, clr2_ff;
   logic [QUOT_W-1:0] quot2_ff, quot2_in;
   logic              v3_ff;
   level_tok_type     tok3_ff, tok3_in;
   logic              ready1, ready2, ready3;
   logic [DIST_W-1:0] dist_mm;
   logic [DIST_W-1:0] depth_ext;

   // stage holds when full and the next one is blocked
   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: echo times speed of sound; timeouts leave no token
   assign v1_in    = in_valid && (in_clear || (in_echo != '0));
   assign prod1_in = PROD_W'(in_echo) * PROD_W'(SOUND_MUL);

   // stage 2: divide by 16 and multiply by the reciprocal of 125
   assign quot2_in = QUOT_W'(prod1_ff[PROD_W-1:PRE_SHIFT]) * QUOT_W'(DIV125_MUL);

   // stage 3: level below the drain depth, clamped at zero
   assign dist_mm   = quot2_ff[DIV125_SHIFT +: DIST_W];
   assign depth_ext = DIST_W'(depth);
   always_comb begin
      tok3_in.clr   = clr2_ff;
      tok3_in.level = '0;
      if (depth_ext > dist_mm) begin
         tok3_in.level = LEVEL_W'(depth_ext - dist_mm);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= v1_in;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ready1) begin
         clr1_ff  <= in_clear;
         prod1_ff <= prod1_in;
      end
      if (ready2) begin
         clr2_ff  <= clr1_ff;
         quot2_ff <= quot2_in;
      end
      if (ready3) begin
         tok3_ff  <= tok3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_tok   = tok3_ff;

endmodule

FILE: sv/wlaf_window.sv
// Moving-sum window: a chain of wlaf_cell, newest level at the head, oldest at the tail.
// Keeps the running sum and the previous sum. Uses wlaf_pkg and wlaf_cell.
module wlaf_window
   import wlaf_pkg::*;
#(
   parameter  int WINDOW = WINDOW_DEFAULT,
   localparam int SUM_W  = $clog2(LEVEL_MAX * WINDOW + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  level_tok_type    in_tok,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [SUM_W-1:0] out_sum,
   output logic [SUM_W-1:0] out_prev
);

   logic               take, take_sample, take_clear, fill, shift;
   logic [LEVEL_W-1:0] cell_d [WINDOW];
   logic [LEVEL_W-1:0] cell_q [WINDOW];
   logic [SUM_W-1:0]   sum_ff, sum_in, prev_ff, prev_in, fill_sum;
   logic [SUM_W:0]     slide_sum;
   logic               first_ff, first_in;
   logic               v_ff, v_in;

   assign in_ready    = !v_ff || out_ready;
   assign take        = in_valid && in_ready;
   assign take_sample = take && !in_tok.clr;
   assign take_clear  = take && in_tok.clr;
   assign fill        = take_sample && first_ff;
   assign shift       = take_sample && !first_ff;

   // row of cells, each handing its level to the next on a shift
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_d[k] = in_tok.level;
      end else begin : g_link
         assign cell_d[k] = cell_q[k-1];
      end
      wlaf_cell u_cell (
         .clock      (clock),
         .fill       (fill),
         .shift      (shift),
         .fill_level (in_tok.level),
         .d_in       (cell_d[k]),
         .q_out      (cell_q[k])
      );
   end

   // sum update: refill, slide, or clear
   assign fill_sum  = SUM_W'(in_tok.level) * SUM_W'(WINDOW);
   assign slide_sum = {1'b0, sum_ff} + (SUM_W+1)'(in_tok.level)
                      - (SUM_W+1)'(cell_q[WINDOW-1]);

   always_comb begin
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      if (take_clear) begin
         sum_in   = '0;
         prev_in  = '0;
         first_in = 1'b1;
      end else if (fill) begin
         sum_in   = fill_sum;
         prev_in  = fill_sum;
         first_in = 1'b0;
      end else if (shift) begin
         sum_in   = slide_sum[SUM_W-1:0];
         prev_in  = sum_ff;
      end
   end

   assign v_in = take_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         prev_ff  <= '0;
         first_ff <= 1'b1;
         v_ff     <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         prev_ff  <= prev_in;
         first_ff <= first_in;
         if (in_ready) v_ff <= v_in;
      end
   end

   assign out_valid = v_ff;
   assign out_sum   = sum_ff;
   assign out_prev  = prev_ff;

   // a clear restarts the window and leaves no sample behind
   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      take_clear |=> first_ff && !v_ff)
      else $error("window not restarted after clear");

endmodule

FILE: sv/wlaf_alert.sv
// Alert pipe: classifies the window sum, then tracks notify and heartbeat state
// into the result register. Uses wlaf_pkg.
module wlaf_alert
   import wlaf_pkg::*;
#(
   parameter  int WINDOW = WINDOW_DEFAULT,
   localparam int SUM_W  = $clog2(LEVEL_MAX * WINDOW + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [SUM_W-1:0] in_sum,
   input  logic [SUM_W-1:0] in_prev,
   input  logic [CFG_W-1:0] depth,
   input  logic [CFG_W-1:0] surge,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp_result
);

   // exact reciprocal of WINDOW over the sum range
   localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
   localparam logic [DIV_SHIFT:0] DIV_MUL =
      (DIV_SHIFT+1)'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam int DPROD_W = SUM_W + DIV_SHIFT + 1;
   localparam int CMP_W   = SUM_W + 4;
   localparam int RISE_W  = (SUM_W + 2 > RISE_OUT_W + 1) ? SUM_W + 2 : RISE_OUT_W + 1;

   logic                      v5_ff, ready5, ready6, take6;
   logic [DPROD_W-1:0]        dprod;
   logic [CMP_W-1:0]          ovf_lhs, ovf_rhs;
   logic signed [RISE_W-1:0]  rise_full, surge_thr;
   logic [LEVEL_W-1:0]        filt5_ff, filt5_in;
   logic [RISE_OUT_W-1:0]     rise5_ff;
   alert_type                 alert5_ff, alert5_in;
   alert_type                 notified_ff, notified_in;
   logic [HB_W-1:0]           hb_cnt_ff, hb_cnt_in, hb_inc;
   logic                      notify, beat;
   logic                      rsp_valid_ff;
   result_type                res_ff, res_in;

   assign ready6   = !rsp_valid_ff || rsp_ready;
   assign ready5   = !v5_ff || ready6;
   assign in_ready = ready5;
   assign take6    = v5_ff && ready6;

   // stage 5: filtered level, rise and alert class
   assign dprod     = DPROD_W'(in_sum) * DPROD_W'(DIV_MUL);
   assign filt5_in  = dprod[DIV_SHIFT +: LEVEL_W];
   assign ovf_lhs   = CMP_W'(in_sum) * CMP_W'(OVF_NUM);
   assign ovf_rhs   = CMP_W'(depth) * CMP_W'(OVF_DEN * WINDOW);
   assign rise_full = $signed(RISE_W'(in_sum)) - $signed(RISE_W'(in_prev));
   assign surge_thr = $signed(RISE_W'(surge) * RISE_W'(WINDOW));

   always_comb begin
      if (ovf_lhs >= ovf_rhs) begin
         alert5_in = ALERT_OVERFLOW;
      end else if (rise_full >= surge_thr) begin
         alert5_in = ALERT_SURGE;
      end else begin
         alert5_in = ALERT_NORMAL;
      end
   end

   // stage 6: notify on a new non-normal alert, heartbeat after six samples
   assign hb_inc = (hb_cnt_ff < HB_SAMPLES) ? hb_cnt_ff + HB_W'(1) : hb_cnt_ff;

   always_comb begin
      notify      = 1'b0;
      notified_in = notified_ff;
      if (alert5_ff == ALERT_NORMAL) begin
         notified_in = ALERT_NORMAL;
      end else if (alert5_ff != notified_ff) begin
         notify      = 1'b1;
         notified_in = alert5_ff;
      end
      beat      = (alert5_ff == ALERT_NORMAL) && (hb_inc >= HB_SAMPLES);
      hb_cnt_in = beat ? '0 : hb_inc;
   end

   always_comb begin
      res_in.heartbeat = beat;
      res_in.notify    = notify;
      res_in.alert     = alert5_ff;
      res_in.rise      = rise5_ff;
      res_in.filtered  = filt5_ff;
   end

   // control and alert state
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         notified_ff  <= ALERT_NORMAL;
         hb_cnt_ff    <= '0;
      end else begin
         if (ready5) v5_ff <= in_valid;
         if (ready6) rsp_valid_ff <= v5_ff;
         if (take6) begin
            notified_ff <= notified_in;
            hb_cnt_ff   <= hb_cnt_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ready5) begin
         filt5_ff  <= filt5_in;
         rise5_ff  <= rise_full[RISE_OUT_W-1:0];
         alert5_ff <= alert5_in;
      end
      if (ready6) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

   a_notify_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.notify |-> res_ff.alert != ALERT_NORMAL)
      else $error("notify on a normal alert");

   a_beat_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.heartbeat |-> res_ff.alert == ALERT_NORMAL)
      else $error("heartbeat on a non-normal alert");

   a_hb_bound: assert property (@(posedge clock) disable iff (reset)
      hb_cnt_ff <= HB_SAMPLES)
      else $error("heartbeat count past its limit");

   a_notified_tracks: assert property (@(posedge clock) disable iff (reset)
      take6 && alert5_ff != ALERT_NORMAL |=> notified_ff == $past(alert5_ff))
      else $error("notified alert not recorded");

endmodule

FILE: verif/wlaf_result_checker.sv
// Scoreboard for the water level alert filter: tracks register writes and input
// transfers, predicts each result and compares it with the result stream.
// Depends on wlaf_pkg for field widths, register indexes and the result layout.
module wlaf_result_checker
   import wlaf_pkg::*;
#(
   parameter logic CLEAR_CODE = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata,
   output int                     errors,
   output int                     pending,
   output int                     results_seen,
   output int                     overflow_seen,
   output int                     surge_seen,
   output int                     notify_seen,
   output int                     beat_seen
);

   // echo in us to distance in mm: speed of sound over the round trip
   localparam int SOUND_DIV = 2000;

   // predictor copy of registers and filter state
   logic [CFG_W-1:0] depth_cfg;
   logic [CFG_W-1:0] surge_cfg;
   int unsigned      level_ring [WINDOW_DEFAULT];
   int unsigned      ring_slot;
   int unsigned      sum_now;
   int unsigned      sum_prev;
   bit               window_empty;
   alert_type        alert_now;
   alert_type        alert_told;
   int unsigned      beat_count;

   result_type       expected_results [$];

   int mismatches = 0;
   int backlog = 0;
   int n_results = 0;
   int n_overflow = 0;
   int n_surge = 0;
   int n_notify = 0;
   int n_beat = 0;

   assign errors        = mismatches;
   assign pending       = backlog;
   assign results_seen  = n_results;
   assign overflow_seen = n_overflow;
   assign surge_seen    = n_surge;
   assign notify_seen   = n_notify;
   assign beat_seen     = n_beat;

   // clear item: window and alert go back to their idle values
   function automatic void drop_window();
      for (int i = 0; i < WINDOW_DEFAULT; i++) begin
         level_ring[i] = 0;
      end
      ring_slot    = 0;
      sum_now      = 0;
      sum_prev     = 0;
      window_empty = 1'b1;
      alert_now    = ALERT_NORMAL;
   endfunction

   // one valid echo sample: update the window and work out its result
   function automatic result_type advance_window(input logic [ECHO_W-1:0] echo);
      int unsigned dist_mm;
      int unsigned lvl;
      int          rise;
      result_type  r;
      dist_mm = (32'(echo) * SOUND_MUL) / SOUND_DIV;
      lvl  = (depth_cfg > dist_mm) ? depth_cfg - dist_mm : 0;
      if (window_empty) begin
         // first sample after reset or clear fills the whole window
         for (int i = 0; i < WINDOW_DEFAULT; i++) begin
            level_ring[i] = lvl;
         end
         sum_now      = lvl * WINDOW_DEFAULT;
         sum_prev     = sum_now;
         window_empty = 1'b0;
      end else begin
         sum_now = sum_now - level_ring[ring_slot] + lvl;
         level_ring[ring_slot] = lvl;
         ring_slot = (ring_slot + 1) % WINDOW_DEFAULT;
      end
      rise = int'(sum_now) - int'(sum_prev);

      // overflow wins over surge
      if (sum_now * OVF_NUM >= depth_cfg * OVF_DEN * WINDOW_DEFAULT)
         alert_now = ALERT_OVERFLOW;
      else if (rise >= int'(surge_cfg) * WINDOW_DEFAULT)
         alert_now = ALERT_SURGE;
      else
         alert_now = ALERT_NORMAL;

      if (beat_count < HB_SAMPLES)
         beat_count++;

      r.notify = 1'b0;
      if (alert_now == ALERT_NORMAL) begin
         alert_told = ALERT_NORMAL;
      end else if (alert_now != alert_told) begin
         r.notify   = 1'b1;
         alert_told = alert_now;
      end

      r.heartbeat = 1'b0;
      if (alert_now == ALERT_NORMAL && beat_count >= HB_SAMPLES) begin
         r.heartbeat = 1'b1;
         beat_count  = 0;
      end

      r.filtered = LEVEL_W'(sum_now / WINDOW_DEFAULT);
      r.rise     = rise[RISE_OUT_W-1:0];
      r.alert    = alert_now;
      sum_prev   = sum_now;
      return r;
   endfunction

   task automatic check_field(input string what, input longint unsigned want,
                              input longint unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, seen);
         mismatches++;
      end
   endtask

   // channel monitor: register writes, result transfers, then input transfers
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         depth_cfg  = DEPTH_RESET;
         surge_cfg  = SURGE_RESET;
         drop_window();
         alert_told = ALERT_NORMAL;
         beat_count = 0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DRAIN_DEPTH: depth_cfg = csr_wdata;
               CSR_SURGE_RISE:  surge_cfg = csr_wdata;
               default: ;
            endcase
         end

         // results leave before the same edge's input is predicted
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got 0x%0h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("filtered_level_mm", want.filtered, got.filtered);
               check_field("rise_fifths_mm", want.rise, got.rise);
               check_field("alert", want.alert, got.alert);
               check_field("notify", want.notify, got.notify);
               check_field("heartbeat", want.heartbeat, got.heartbeat);
               check_field("tdata padding", 0, rsp_tdata[RSP_TDATA_W-1:RESULT_W]);
               n_results++;
               if (want.alert == ALERT_OVERFLOW) n_overflow++;
               if (want.alert == ALERT_SURGE) n_surge++;
               if (want.notify) n_notify++;
               if (want.heartbeat) n_beat++;
            end
         end

         // timeouts and clears give no result
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == CLEAR_CODE)
               drop_window();
            else if (req_tdata[ECHO_W-1:0] != '0)
               expected_results.push_back(advance_window(req_tdata[ECHO_W-1:0]));
         end
      end
      backlog <= expected_results.size();
   end

endmodule

FILE: verif/tb_water_level_alert_filter_top.sv
// Testbench top for water_level_alert_filter_top: clock, reset, sample stimulus,
// register settings and result back-pressure, with the verdict at the end.
// Depends on wlaf_pkg, wlaf_result_checker and the block itself.
module tb_water_level_alert_filter_top;
   import wlaf_pkg::*;

   localparam logic ACT_SAMPLE   = 1'b0;
   localparam logic ACT_CLEAR    = 1'b1;
   localparam int   PIPE_LATENCY = 6;
   localparam int   DRAIN_GUARD  = 5000;
   localparam int   LONG_HOLD    = 80;
   localparam int   TIME_LIMIT   = 5_000_000;
   localparam int   PHASES       = 12;
   localparam int   PHASE_ITEMS  = 125;
   // inverse of the distance scale, used to aim echoes at a target level
   localparam int   US_PER_MM_NUM = 2000;
   localparam int   US_PER_MM_DEN = 343;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [15:0] echo_us
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // [0] action
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // [12:0] level, [29:13] rise, [31:30] alert,
                                            // [32] notify, [33] heartbeat
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   int errors, pending, results_seen, overflow_seen, surge_seen, notify_seen, beat_seen;

   // stimulus bookkeeping
   int          burst_left = 0;
   bit          steady_send = 1'b0;
   int          stall_request = 0;
   int          stall_served = 0;
   int unsigned depth_now = DEPTH_RESET;
   int          n_samples = 0;
   int          n_timeouts = 0;
   int          n_clears = 0;
   int          n_settings = 1;
   int          input_stalls = 0;

   always #5 clock = ~clock;

   water_level_alert_filter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   wlaf_result_checker #(.CLEAR_CODE(ACT_CLEAR)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .errors        (errors),
      .pending       (pending),
      .results_seen  (results_seen),
      .overflow_seen (overflow_seen),
      .surge_seen    (surge_seen),
      .notify_seen   (notify_seen),
      .beat_seen     (beat_seen)
   );

   // one input transfer; bursts of random length separated by random gaps
   task automatic offer(input logic act, input logic [ECHO_W-1:0] echo);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= echo;
      do begin
         @(posedge clock);
         if (!req_tready) input_stalls++;
      end while (!req_tready);
      if (act == ACT_CLEAR) n_clears++;
      else if (echo == 0) n_timeouts++;
      else n_samples++;
   endtask

   // stop sending and let every expected result come out, then the pipe go quiet
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // both registers, back to back, only while the block is idle
   task automatic set_thresholds(input int unsigned depth, input int unsigned rise);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_DRAIN_DEPTH;
      csr_wdata <= CFG_W'(depth);
      @(posedge clock);
      csr_addr  <= CSR_SURGE_RISE;
      csr_wdata <= CFG_W'(rise);
      @(posedge clock);
      csr_we    <= 1'b0;
      depth_now = depth;
      n_settings++;
   endtask

   // mostly level trends with random content, plus noise, timeouts and clears
   task automatic random_phase(input int count);
      int unsigned target, step, dist_mm, echo_i, pick;
      int          k;
      target = $urandom_range(0, depth_now);
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            offer(ACT_CLEAR, ECHO_W'($urandom));
         end else if (pick < 8) begin
            offer(ACT_SAMPLE, '0);
         end else if (pick < 18) begin
            offer(ACT_SAMPLE, ECHO_W'($urandom_range(1, 65535)));
         end else begin
            if (pick < 23) begin
               target = $urandom_range(0, depth_now);
            end else begin
               step = $urandom_range(0, depth_now / 5 + 1);
               if ($urandom_range(0, 1)) target = target + step;
               else target = (target > step) ? target - step : 0;
               if (target > depth_now) target = depth_now;
            end
            dist_mm = depth_now - target;
            echo_i  = (dist_mm * US_PER_MM_NUM + $urandom_range(0, US_PER_MM_NUM - 1))
                      / US_PER_MM_DEN;
            if (echo_i == 0) echo_i = 1;
            if (echo_i > 65535) echo_i = 65535;
            offer(ACT_SAMPLE, ECHO_W'(echo_i));
         end
      end
   endtask

   // receiver: changing stall patterns, and a long hold-off on request
   initial begin : rx_pattern
      rx_mode_type mode;
      int          mode_left;
      mode      = RX_OPEN;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request != stall_served) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            stall_served = stall_request;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
               default:   rsp_tready <= ((mode_left % 5) < 3);
            endcase
         end
      end
   end

   // run limit
   initial begin
      #(TIME_LIMIT);
      $display("%0t: run did not finish in time, %0d results outstanding", $time, pending);
      $display("** water_level_alert_filter_top: FAILED **");
      $finish;
   end

   // main sequence
   initial begin
      int unsigned depth_list [PHASES];
      int unsigned surge_list [PHASES];
      int          p;
      depth_list = '{4000, 0, 8191, 6800, 1, 2500, 8191, 300, 6800, 0, 0, 0};
      surge_list = '{50, 0, 8191, 0, 8191, 20, 0, 1, 400, 8191, 0, 0};
      depth_list[10] = $urandom_range(0, 8191);
      surge_list[10] = $urandom_range(0, 8191);
      depth_list[11] = $urandom_range(0, 8191);
      surge_list[11] = $urandom_range(0, 8191);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: first fill, timeout, clear ignoring echo, long echo clamp,
      // surge then overflow, fall back to normal with a heartbeat, wide echoes
      offer(ACT_SAMPLE, 16'd1000);
      offer(ACT_SAMPLE, 16'd0);
      offer(ACT_CLEAR, 16'hFFFF);
      offer(ACT_SAMPLE, 16'hFFFF);
      offer(ACT_SAMPLE, 16'd20000);
      repeat (5) offer(ACT_SAMPLE, 16'd1);
      offer(ACT_CLEAR, 16'd0);
      repeat (8) offer(ACT_SAMPLE, 16'd40000);
      offer(ACT_SAMPLE, 16'h8000);
      offer(ACT_SAMPLE, 16'h7FFF);
      offer(ACT_SAMPLE, 16'h5555);
      offer(ACT_SAMPLE, 16'hAAAA);

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            set_thresholds(depth_list[p], surge_list[p]);
         end
         random_phase(PHASE_ITEMS);
         // receiver holds off while the sender keeps offering
         if (p == 0 || p == 5) begin
            steady_send = 1'b1;
            stall_request++;
            random_phase(40);
            steady_send = 1'b0;
         end
      end
      settle();

      $display("Covered %0d samples, %0d timeouts and %0d clears over %0d threshold settings;",
               n_samples, n_timeouts, n_clears, n_settings);
      $display({"checked %0d results (%0d overflow, %0d surge, %0d notify, %0d heartbeat), ",
                "%0d input stall cycles."},
               results_seen, overflow_seen, surge_seen, notify_seen, beat_seen, input_stalls);
      if (pending != 0)
         $display("%0t: %0d expected results never arrived", $time, pending);
      if (errors == 0 && pending == 0) begin
         $display("** water_level_alert_filter_top: PASSED **");
      end else begin
         $display("** water_level_alert_filter_top: FAILED **");
      end
      $finish;
   end

endmodule
